FILE: rtl/lkvc_pkg.sv
// shared types, constants and codes for the lru key-value cache
package lkvc_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int CAP_W           = 5;
    localparam int DATA_W          = 32;
    localparam int PADDR_W         = 3;
    localparam int PDATA_W         = 32;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
    localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

    // register index of the capacity register
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } t_opcode;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] lookup_key;
        logic signed [31:0] store_value;
    } t_item;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] read_value;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_COMPARE = 2'd1,
        ST_UPDATE  = 2'd2
    } t_state;

    typedef struct packed {
        logic capture;
        logic compare;
        logic write_front;
        logic insert;
        logic respond;
    } t_dp_cmd;

    typedef struct packed {
        logic is_put;
        logic hit;
    } t_dp_status;

endpackage

FILE: rtl/lkvc_ctrl.sv
// controller state machine for the lru key-value cache
module lkvc_ctrl
    import lkvc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_COMPARE;
                end
            end
            ST_COMPARE: begin
                o_cmd.compare = 1'b1;
                n_state       = ST_UPDATE;
            end
            ST_UPDATE: begin
                o_cmd.write_front = i_status.hit || i_status.is_put;
                o_cmd.insert      = i_status.is_put && !i_status.hit;
                o_cmd.respond     = !i_status.is_put;
                n_state           = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

FILE: rtl/lkvc_datapath.sv
// recency chain of key/value cells, parallel compare and move-to-front shift
module lkvc_datapath
    import lkvc_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_item            i_item,
    input  logic [CAP_W-1:0] i_capacity,
    input  t_dp_cmd          i_cmd,
    output t_dp_status       o_status,
    output logic             o_result_valid,
    output t_result          o_result
);

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int EW = (CW > CAP_W) ? CW : CAP_W;

    // cell 0 is the most recent
    logic [DATA_W-1:0] r_key_cell [MAX_ENTRIES];
    logic [DATA_W-1:0] r_val_cell [MAX_ENTRIES];
    logic [CW-1:0]     r_count;

    logic              r_op;
    logic [DATA_W-1:0] r_key;
    logic [DATA_W-1:0] r_val;
    logic              r_hit;
    logic [IW-1:0]     r_pos;
    logic [DATA_W-1:0] r_hit_value;

    logic              r_res_valid;
    t_result           r_res;

    logic [MAX_ENTRIES-1:0] match;
    logic [IW-1:0]          n_pos;
    logic [DATA_W-1:0]      n_hit_value;
    logic [EW-1:0]          cap_ext;
    logic [CW-1:0]          eff_cap;
    logic [CW-1:0]          kept_count;
    logic [IW-1:0]          shift_lim;
    logic [DATA_W-1:0]      front_val;

    // parallel compare over the valid cells
    always_comb begin
        n_pos       = '0;
        n_hit_value = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            match[i] = (CW'(i) < r_count) && (r_key_cell[i] == r_key);
            if (match[i]) begin
                n_pos       = n_pos | IW'(i);
                n_hit_value = n_hit_value | r_val_cell[i];
            end
        end
    end

    // zero acts as one, values above the depth saturate
    always_comb begin
        cap_ext = EW'(i_capacity);
        if (cap_ext == '0) begin
            eff_cap = CW'(1);
        end else if (cap_ext > EW'(MAX_ENTRIES)) begin
            eff_cap = CW'(MAX_ENTRIES);
        end else begin
            eff_cap = CW'(cap_ext);
        end
        kept_count = (r_count >= eff_cap) ? (eff_cap - CW'(1)) : r_count;
        shift_lim  = r_hit ? r_pos : IW'(MAX_ENTRIES - 1);
        front_val  = (r_op == OP_PUT) ? r_val : r_hit_value;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_item.opcode;
            r_key <= i_item.lookup_key;
            r_val <= i_item.store_value;
        end
        if (i_cmd.compare) begin
            r_hit       <= |match;
            r_pos       <= n_pos;
            r_hit_value <= n_hit_value;
        end
        if (i_cmd.write_front) begin
            r_key_cell[0] <= r_key;
            r_val_cell[0] <= front_val;
            for (int i = 1; i < MAX_ENTRIES; i++) begin
                if (IW'(i) <= shift_lim) begin
                    r_key_cell[i] <= r_key_cell[i-1];
                    r_val_cell[i] <= r_val_cell[i-1];
                end
            end
        end
        r_res.hit        <= r_hit;
        r_res.read_value <= r_hit ? r_hit_value : MISS_VALUE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= i_cmd.respond;
            if (i_cmd.insert) begin
                r_count <= kept_count + CW'(1);
            end
        end
    end

    assign o_status.is_put = r_op;
    assign o_status.hit    = r_hit;
    assign o_result_valid  = r_res_valid;
    assign o_result        = r_res;

endmodule

FILE: rtl/lru_key_value_cache.sv
// top level of the lru key-value cache: apb register, controller and datapath
// a get is captured, compared, then its result and strobe are registered from the update state
// a new request is taken only while idle; busy covers the compare and update states
// a put gives no result, a get gives exactly one; the receiver cannot stall
// the recency chain is compared in parallel, then shifted to the front in a single update
// reset (synchronous, active low) empties the cache and sets capacity to 16
module lru_key_value_cache
    import lkvc_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request transfer
    input  logic               start,
    output logic               busy,
    input  t_item              i_item,
    // result transfer, one cycle strobe
    output logic               o_result_valid,
    output t_result            o_result,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [CAP_W-1:0] r_capacity;
    logic             reg_index;
    t_dp_cmd          dp_cmd;
    t_dp_status       dp_status;

    // word address selects the register
    assign reg_index = paddr[2];
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (psel && penable && pwrite && (reg_index == REG_CAPACITY)) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    // read back, unused addresses read zero
    always_comb begin
        prdata = '0;
        if (reg_index == REG_CAPACITY) begin
            prdata = PDATA_W'(r_capacity);
        end
    end

    lkvc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (dp_status),
        .o_cmd    (dp_cmd),
        .o_busy   (busy)
    );

    lkvc_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (i_item),
        .i_capacity     (r_capacity),
        .i_cmd          (dp_cmd),
        .o_status       (dp_status),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule
